// ===== hdl/klt_pkg.sv =====
// Shared types and constants for the key lookup-or-insert table.
package klt_pkg;

  localparam int unsigned EXCH_W       = 32;
  localparam int unsigned ITEM_W       = 64;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned SLOT_INDEX_W = 6;

  localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  localparam logic [7:0] EMPTY_BYTE = 8'h00;

  typedef struct packed {
    logic valid;
    logic found;
    logic have_empty;
  } cell_tok_t;

endpackage

// ===== hdl/klt_cell.sv =====
// One slot of the table: holds a key, checks the passing request, hands it on.
module klt_cell #(
  parameter int unsigned IDX_W    = 6,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [klt_pkg::EXCH_W-1:0]     exch_i,
  input  logic [klt_pkg::ITEM_W-1:0]     hi_i,
  input  logic [klt_pkg::ITEM_W-1:0]     lo_i,
  input  klt_pkg::cell_tok_t             tok_i,
  input  logic [IDX_W-1:0]               idx_i,
  output klt_pkg::cell_tok_t             tok_o,
  output logic [IDX_W-1:0]               idx_o,
  input  logic                           wr_en_i,
  input  logic [IDX_W-1:0]               wr_idx_i
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [klt_pkg::EXCH_W-1:0] exch_q;
  logic [klt_pkg::ITEM_W-1:0] hi_q;
  logic [klt_pkg::ITEM_W-1:0] lo_q;
  klt_pkg::cell_tok_t         tok_q, tok_d;
  logic [IDX_W-1:0]           idx_q, idx_d;
  logic                       hit;
  logic                       empty;

  assign hit   = (exch_q == exch_i) && (hi_q == hi_i) && (lo_q == lo_i);
  assign empty = (hi_q[klt_pkg::ITEM_W-1 -: 8] == klt_pkg::EMPTY_BYTE);

  always_comb begin
    tok_d.valid      = tok_i.valid;
    tok_d.found      = tok_i.found | hit;
    tok_d.have_empty = tok_i.have_empty | empty;
    priority if (tok_i.found) begin
      idx_d = idx_i;
    end else if (hit) begin
      idx_d = MY_IDX;
    end else if (tok_i.have_empty) begin
      idx_d = idx_i;
    end else if (empty) begin
      idx_d = MY_IDX;
    end else begin
      idx_d = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= '0;
      idx_q  <= '0;
      exch_q <= '0;
      hi_q   <= '0;
      lo_q   <= '0;
    end else begin
      tok_q <= tok_d;
      idx_q <= idx_d;
      if (wr_en_i && (wr_idx_i == MY_IDX)) begin
        exch_q <= exch_i;
        hi_q   <= hi_i;
        lo_q   <= lo_i;
      end
    end
  end

  assign tok_o = tok_q;
  assign idx_o = idx_q;

endmodule

// ===== hdl/key_lookup_or_insert_table.sv =====
// Top level of the key lookup-or-insert table: request chain and result register.
//
// Input channel: in_valid_i / in_stall_o with the key fields exchange_code_i,
// item_code_hi_i and item_code_lo_i. A request is taken when valid is high and
// stall is low. Output channel: out_valid_o / out_stall_i with status_o
// (found, inserted or full) and slot_index_o.
// The key is masked to its significant bytes and held while a request token
// travels down a chain of ENTRIES cells, one cell per cycle; each cell
// compares its stored slot against the key and updates the match / first
// empty bookkeeping. At the chain end a miss with a free slot writes the key
// into that slot.
// The token passes from the start register through the cell chain into the
// pending register and then the output register. One request is in flight
// at a time; the next is taken after the previous result reaches the output.
// A finished result waits in the output register while out_stall_i is high;
// the next request is accepted meanwhile, and its result waits in a pending
// register until the output frees up.
// Reset clears every slot to zero (all slots empty) and drops all requests.
module key_lookup_or_insert_table #(
  parameter int unsigned ENTRIES    = 64,
  parameter int unsigned EXCH_BYTES = 4,
  parameter int unsigned ITEM_BYTES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [klt_pkg::EXCH_W-1:0]        exchange_code_i,
  input  logic [klt_pkg::ITEM_W-1:0]        item_code_hi_i,
  input  logic [klt_pkg::ITEM_W-1:0]        item_code_lo_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [klt_pkg::STATUS_W-1:0]      status_o,
  output logic [klt_pkg::SLOT_INDEX_W-1:0]  slot_index_o
);

  localparam int unsigned IDX_W     = $clog2(ENTRIES);
  localparam int unsigned SIW       = klt_pkg::SLOT_INDEX_W;
  localparam int unsigned EXCH_KEEP = (EXCH_BYTES > 4) ? 4 : EXCH_BYTES;
  localparam int unsigned LO_KEEP   = ITEM_BYTES - 8;
  localparam logic [klt_pkg::EXCH_W-1:0] EXCH_MASK =
    klt_pkg::EXCH_W'((64'd1 << (8 * EXCH_KEEP)) - 64'd1);
  localparam logic [klt_pkg::ITEM_W-1:0] LO_MASK =
    {klt_pkg::ITEM_W{1'b1}} << (8 * (8 - LO_KEEP));

  logic [klt_pkg::EXCH_W-1:0]   exch_q;
  logic [klt_pkg::ITEM_W-1:0]   hi_q;
  logic [klt_pkg::ITEM_W-1:0]   lo_q;
  logic                         busy_q;
  logic                         start_q;
  logic                         pend_valid_q;
  logic [klt_pkg::STATUS_W-1:0] pend_status_q, pend_status_d;
  logic [SIW-1:0]               pend_idx_q, pend_idx_d;
  logic                         out_valid_q;
  logic [klt_pkg::STATUS_W-1:0] status_q;
  logic [SIW-1:0]               slot_index_q;

  klt_pkg::cell_tok_t           tok [ENTRIES+1];
  logic [IDX_W-1:0]             idx [ENTRIES+1];
  klt_pkg::cell_tok_t           tok_last;
  logic                         wr_en;
  logic                         in_acc;
  logic                         out_free;
  logic                         move;

  assign in_acc   = in_valid_i && !busy_q;
  assign out_free = !out_valid_q || !out_stall_i;
  assign move     = pend_valid_q && out_free;

  assign tok[0].valid      = start_q;
  assign tok[0].found      = 1'b0;
  assign tok[0].have_empty = 1'b0;
  assign idx[0]            = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    klt_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .exch_i   (exch_q),
      .hi_i     (hi_q),
      .lo_i     (lo_q),
      .tok_i    (tok[g]),
      .idx_i    (idx[g]),
      .tok_o    (tok[g+1]),
      .idx_o    (idx[g+1]),
      .wr_en_i  (wr_en),
      .wr_idx_i (idx[ENTRIES])
    );
  end

  assign tok_last = tok[ENTRIES];
  assign wr_en    = tok_last.valid && !tok_last.found && tok_last.have_empty;

  always_comb begin
    priority if (tok_last.found) begin
      pend_status_d = klt_pkg::ST_FOUND;
      pend_idx_d    = SIW'(idx[ENTRIES]);
    end else if (tok_last.have_empty) begin
      pend_status_d = klt_pkg::ST_INSERTED;
      pend_idx_d    = SIW'(idx[ENTRIES]);
    end else begin
      pend_status_d = klt_pkg::ST_FULL;
      pend_idx_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      start_q      <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      start_q <= in_acc;
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (move) begin
        busy_q <= 1'b0;
      end
      if (tok_last.valid) begin
        pend_valid_q <= 1'b1;
      end else if (move) begin
        pend_valid_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      exch_q <= exchange_code_i & EXCH_MASK;
      hi_q   <= item_code_hi_i;
      lo_q   <= item_code_lo_i & LO_MASK;
    end
    if (tok_last.valid) begin
      pend_status_q <= pend_status_d;
      pend_idx_q    <= pend_idx_d;
    end
    if (move) begin
      status_q     <= pend_status_q;
      slot_index_q <= pend_idx_q;
    end
  end

  assign in_stall_o   = busy_q;
  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign slot_index_o = slot_index_q;

endmodule

// ===== hdl/klt_checker.sv =====
// Port-level checks for the key lookup-or-insert table, bound to the top level.
module klt_port_checks (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [klt_pkg::STATUS_W-1:0]      status_o,
  input logic [klt_pkg::SLOT_INDEX_W-1:0]  slot_index_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(status_o) && $stable(slot_index_o))
    else $error("stalled result changed");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while another is in flight");

  a_full_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == klt_pkg::ST_FULL) |-> slot_index_o == '0)
    else $error("full result with nonzero index");

  a_no_fast_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared right after request");

endmodule

bind key_lookup_or_insert_table klt_port_checks u_klt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .slot_index_o (slot_index_o)
);

// ===== verif/klt_checker.sv =====
// Checker for the key lookup-or-insert table: slot table predictor and result comparison.
module klt_checker #(
  parameter int unsigned ENTRIES    = 64,
  parameter int unsigned EXCH_BYTES = 4,
  parameter int unsigned ITEM_BYTES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [klt_pkg::EXCH_W-1:0]        exchange_code_i,
  input  logic [klt_pkg::ITEM_W-1:0]        item_code_hi_i,
  input  logic [klt_pkg::ITEM_W-1:0]        item_code_lo_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic [klt_pkg::STATUS_W-1:0]      status_i,
  input  logic [klt_pkg::SLOT_INDEX_W-1:0]  slot_index_i,
  input  logic                              end_of_test_i,
  output int                                mismatches_o,
  output int                                pending_o,
  output int                                found_o,
  output int                                inserted_o,
  output int                                full_o
);
  import klt_pkg::*;

  localparam int unsigned EXCH_KEEP = (EXCH_BYTES < 1) ? 1 : ((EXCH_BYTES > 4) ? 4 : EXCH_BYTES);
  localparam int unsigned LO_KEEP   = (ITEM_BYTES < 9) ? 1 :
                                      ((ITEM_BYTES > 16) ? 8 : ITEM_BYTES - 8);
  localparam logic [63:0] EXCH_MASK_W = (64'd1 << (8 * EXCH_KEEP)) - 64'd1;
  localparam logic [EXCH_W-1:0] EXCH_MASK = EXCH_MASK_W[EXCH_W-1:0];
  localparam logic [ITEM_W-1:0] LO_MASK = {ITEM_W{1'b1}} << (8 * (8 - LO_KEEP));

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [SLOT_INDEX_W-1:0] index;
  } answer_t;

  logic [EXCH_W-1:0] slot_exch [ENTRIES];
  logic [ITEM_W-1:0] slot_hi   [ENTRIES];
  logic [ITEM_W-1:0] slot_lo   [ENTRIES];
  answer_t           answer_q  [$];
  logic              leftover_flagged;

  // Search for the key first, then claim the lowest empty slot.
  function automatic answer_t lookup_or_insert(input logic [EXCH_W-1:0] ex_raw,
                                               input logic [ITEM_W-1:0] hi,
                                               input logic [ITEM_W-1:0] lo_raw);
    answer_t           a;
    logic [EXCH_W-1:0] ex;
    logic [ITEM_W-1:0] lo;
    int                free_slot;
    ex        = ex_raw & EXCH_MASK;
    lo        = lo_raw & LO_MASK;
    free_slot = -1;
    for (int s = 0; s < ENTRIES; s++) begin
      if (slot_exch[s] == ex && slot_hi[s] == hi && slot_lo[s] == lo) begin
        a.status = ST_FOUND;
        a.index  = SLOT_INDEX_W'(s);
        return a;
      end
      if (free_slot < 0 && slot_hi[s][ITEM_W-1 -: 8] == EMPTY_BYTE) begin
        free_slot = s;
      end
    end
    if (free_slot >= 0) begin
      slot_exch[free_slot] = ex;
      slot_hi[free_slot]   = hi;
      slot_lo[free_slot]   = lo;
      a.status = ST_INSERTED;
      a.index  = SLOT_INDEX_W'(free_slot);
    end else begin
      a.status = ST_FULL;
      a.index  = '0;
    end
    return a;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] lookup table mismatch: %s", $time, what);
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t exp_a;
    answer_t new_a;
    if (!rst_ni) begin
      for (int s = 0; s < ENTRIES; s++) begin
        slot_exch[s] = '0;
        slot_hi[s]   = '0;
        slot_lo[s]   = '0;
      end
      answer_q.delete();
      leftover_flagged = 1'b0;
      mismatches_o     = 0;
      found_o          = 0;
      inserted_o       = 0;
      full_o           = 0;
      pending_o       <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (answer_q.size() == 0) begin
          report_mismatch($sformatf("result with no request pending: status %0d slot %0d",
                                    status_i, slot_index_i));
        end else begin
          exp_a = answer_q.pop_front();
          if (status_i !== exp_a.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", status_i, exp_a.status));
          end
          if (slot_index_i !== exp_a.index) begin
            report_mismatch($sformatf("slot index %0d, expected %0d (status %0d)",
                                      slot_index_i, exp_a.index, exp_a.status));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        new_a = lookup_or_insert(exchange_code_i, item_code_hi_i, item_code_lo_i);
        answer_q.push_back(new_a);
        case (new_a.status)
          ST_FOUND:    found_o++;
          ST_INSERTED: inserted_o++;
          default:     full_o++;
        endcase
      end
      if (end_of_test_i && !leftover_flagged && answer_q.size() != 0) begin
        leftover_flagged = 1'b1;
        report_mismatch($sformatf("%0d results never arrived", answer_q.size()));
      end
      pending_o <= answer_q.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the key lookup-or-insert table: stimulus, stall patterns and verdict.
module tb_top;
  import klt_pkg::*;

  localparam int unsigned ENTRIES        = 64;
  localparam int unsigned N_DIRECTED     = 16;
  localparam int unsigned N_RANDOM       = 1134;
  localparam int unsigned PHASE_LEN      = N_RANDOM / 3;
  localparam int unsigned HISTORY_DEPTH  = 200;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic [EXCH_W-1:0] exch;
    logic [ITEM_W-1:0] hi;
    logic [ITEM_W-1:0] lo;
  } key_t;

  logic                    clk           = 1'b0;
  logic                    rst_n         = 1'b0;
  logic                    in_valid      = 1'b0;
  logic                    in_stall;
  logic [EXCH_W-1:0]       exchange_code = '0;
  logic [ITEM_W-1:0]       item_code_hi  = '0;
  logic [ITEM_W-1:0]       item_code_lo  = '0;
  logic                    out_valid;
  logic                    out_stall     = 1'b0;
  logic [STATUS_W-1:0]     status;
  logic [SLOT_INDEX_W-1:0] slot_index;
  logic                    end_of_test   = 1'b0;
  int                      tx_idle_pct   = 0;
  int                      rx_idle_pct   = 0;
  int                      idle_cycles   = 0;
  int                      mismatches;
  int                      pending;
  int                      n_found;
  int                      n_inserted;
  int                      n_full;
  key_t                    sent_keys [$];

  // Empty-slot keys (zero first byte), all-zero key matching past an empty
  // slot, overwrites of empty slots, single-bit neighbors and field extremes.
  key_t directed_keys [N_DIRECTED] = '{
    '{32'h0, 64'h0, 64'h0},
    '{'1, '1, '1},
    '{'1, '1, '1},
    '{32'h0, 64'h0100_0000_0000_0000, 64'h0},
    '{32'hFFFF_FFFF, 64'h00FF_FFFF_FFFF_FFFF, '1},
    '{32'h0, 64'h0, 64'h0},
    '{32'hFFFF_FFFF, 64'h00FF_FFFF_FFFF_FFFF, '1},
    '{32'h1, 64'h0000_0000_0000_0001, 64'h1},
    '{32'hFFFF_FFFF, 64'h00FF_FFFF_FFFF_FFFF, '1},
    '{32'h0, 64'h8000_0000_0000_0000, 64'h0},
    '{32'hFFFF_FFFE, '1, '1},
    '{'1, '1, 64'hFFFF_FFFF_FFFF_FFFE},
    '{'1, 64'h7FFF_FFFF_FFFF_FFFF, '1},
    '{32'h8000_0000, 64'hFF00_0000_0000_0000, 64'h8000_0000_0000_0000},
    '{'1, '1, '1},
    '{32'h0, 64'h0, 64'h0}
  };

  always #5 clk = ~clk;

  key_lookup_or_insert_table #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .exchange_code_i(exchange_code),
    .item_code_hi_i (item_code_hi),
    .item_code_lo_i (item_code_lo),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .slot_index_o   (slot_index)
  );

  klt_checker #(
    .ENTRIES(ENTRIES)
  ) checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .exchange_code_i(exchange_code),
    .item_code_hi_i (item_code_hi),
    .item_code_lo_i (item_code_lo),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .status_i       (status),
    .slot_index_i   (slot_index),
    .end_of_test_i  (end_of_test),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .found_o        (n_found),
    .inserted_o     (n_inserted),
    .full_o         (n_full)
  );

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no request or result moved for %0d cycles", idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_request(input key_t k);
    int gap;
    if ($urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(80, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    exchange_code <= k.exch;
    item_code_hi  <= k.hi;
    item_code_lo  <= k.lo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_keys.push_back(k);
    if (sent_keys.size() > HISTORY_DEPTH) begin
      void'(sent_keys.pop_front());
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    key_t k;
    int   r;
    int   fresh_pct;
    repeat (10) @(posedge clk);
    rst_n       <= 1'b1;
    tx_idle_pct <= 17;
    rx_idle_pct <= 75;
    @(posedge clk);

    foreach (directed_keys[i]) begin
      send_request(directed_keys[i]);
    end
    drain_results();

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == PHASE_LEN) begin
        drain_results();
        tx_idle_pct <= 75;
        rx_idle_pct <= 17;
      end else if (n == 2 * PHASE_LEN) begin
        drain_results();
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
      end
      // new keys trickle in slowly at first, then fill the table
      fresh_pct = (n < 500) ? 5 : 15;
      r = $urandom_range(99);
      if (r < 15) begin
        k = {$urandom, $urandom, $urandom, $urandom, $urandom};
        k.hi[ITEM_W-1 -: 8] = EMPTY_BYTE;
        if ($urandom_range(9) == 0) begin
          k = '0;
        end
      end else if (r < 15 + fresh_pct) begin
        if ($urandom_range(1) == 1) begin
          k = {$urandom, $urandom, $urandom, $urandom, $urandom};
        end else begin
          k = sent_keys[$urandom_range(sent_keys.size() - 1)];
          k = k ^ (160'd1 << $urandom_range(159));
        end
      end else begin
        k = sent_keys[$urandom_range(sent_keys.size() - 1)];
      end
      send_request(k);
    end

    drain_results();
    repeat (ENTRIES + 8) @(posedge clk);
    end_of_test <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Ran %0d directed and %0d random lookups under three sender/receiver stall mixes.",
             N_DIRECTED, N_RANDOM);
    $display("Outcomes seen: %0d found, %0d inserted, %0d table full.",
             n_found, n_inserted, n_full);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
